// ===== src/block_fit_allocator_assert.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef BLOCK_FIT_ALLOCATOR_ASSERT_SVH
`define BLOCK_FIT_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define BFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("allocator assertion failed");
// Next-cycle implication, disabled during reset.
`define BFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("allocator assertion failed");
`else
`define BFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/bfa_pkg.sv =====
// Constants and codes for the block fit allocator.
`default_nettype none
package bfa_pkg;
	localparam int NUM_BLOCKS = 64;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_BITS   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);
	localparam int BC_W       = 7;
	localparam int CMP_W      = (CNT_BITS > BC_W) ? CNT_BITS : BC_W;

	// action codes
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_ALLOC = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// fit policies
	localparam logic [1:0] MODE_FIRST = 2'd0;
	localparam logic [1:0] MODE_BEST  = 2'd1;
	localparam logic [1:0] MODE_WORST = 2'd2;

	// config register indexes
	localparam logic [1:0] CFG_FIT_MODE    = 2'd0;
	localparam logic [1:0] CFG_BLOCK_COUNT = 2'd1;
endpackage
`default_nettype wire

// ===== src/block_fit_allocator.sv =====
// Top level: free-space table with first, best and worst fit allocation.
//
// Usage:
//  - Command channel: an item transfers at a rising edge with start high and
//    busy low. action selects load (write a block's size), allocate (search
//    for a block that holds amount) or read (return a block's space).
//  - Result: exactly one per item, shown for one cycle with done high. The
//    receiver cannot stall; done is never withheld.
//  - Sequence: load and unused actions answer in the cycle after the
//    transfer (unused with granted low); a read passes ST_READ; allocate
//    scans block_count entries, saturated to the table size, then ST_FIN.
//  - Throughput: one item at a time; busy drops in the cycle done is shown,
//    so a new item may transfer then. The allocate rate is set by the table
//    RAM read port: one entry is examined per cycle, then the chosen entry
//    is written back in ST_FIN if one was found.
//  - Config channel: cfg_ready is high while busy is low; index 0 is fit_mode,
//    index 1 block_count. Writes are taken only while no item is in flight.
//  - Reset: fit_mode 0, block_count 64, and every table entry reads as zero
//    at once (per-entry valid flops mask the RAM until an entry is written).
`default_nettype none
`include "block_fit_allocator_assert.svh"
module block_fit_allocator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  action,
	input  wire logic [5:0]  block_sel,
	input  wire logic [15:0] amount,
	output logic             done,
	output logic             granted,
	output logic [5:0]       block_index,
	output logic [15:0]      space_left,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [6:0]  cfg_data
);
	localparam int IW = bfa_pkg::IDX_BITS;
	localparam int SW = bfa_pkg::SIZE_BITS;
	localparam int CW = bfa_pkg::CNT_BITS;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]    state_q;
	logic [1:0]    fit_mode_q;
	logic [6:0]    block_count_q;

	logic [bfa_pkg::NUM_BLOCKS-1:0] valid_q;

	// allocation search state
	logic [SW-1:0] job_q;
	logic [CW-1:0] limit_q;
	logic [CW-1:0] rd_q;
	logic          found_q;
	logic [SW-1:0] best_left_q;
	logic [IW-1:0] best_idx_q;

	// read pipeline: entry index and valid flag aligned to RAM data
	logic          chk_s1;
	logic [IW-1:0] idx_s1;
	logic          vld_s1;

	// RAM ports
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [SW-1:0] ram_wdata;
	logic          ram_re;
	logic [IW-1:0] ram_raddr;
	logic [SW-1:0] ram_rdata;

	logic          take;
	logic          in_table;
	logic          issue;
	logic [SW-1:0] amt;
	logic [SW-1:0] space;
	logic [SW-1:0] left;
	logic          fits;
	logic          better;
	logic [bfa_pkg::CMP_W-1:0] bc_ext;
	logic [CW-1:0] limit_d;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign take      = start && !busy;
	assign in_table  = (32'(block_sel) < 32'(bfa_pkg::NUM_BLOCKS));
	assign amt       = SW'(amount);
	assign issue     = (rd_q < limit_q);

	// search range, saturated to the table size
	assign bc_ext  = bfa_pkg::CMP_W'(block_count_q);
	assign limit_d = (bc_ext > bfa_pkg::CMP_W'(bfa_pkg::NUM_BLOCKS)) ?
		CW'(bfa_pkg::NUM_BLOCKS) : CW'(bc_ext);

	// entry value as seen through the valid mask
	assign space = vld_s1 ? ram_rdata : '0;
	assign fits  = (space >= job_q);
	assign left  = space - job_q;

	always_comb begin
		case (fit_mode_q)
			bfa_pkg::MODE_BEST:  better = !found_q || (left < best_left_q);
			bfa_pkg::MODE_WORST: better = !found_q || (left > best_left_q);
			default:             better = !found_q;
		endcase
	end

	// RAM access steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = IW'(block_sel);
		ram_wdata = amt;
		ram_re    = 1'b0;
		ram_raddr = IW'(block_sel);
		case (state_q)
			ST_IDLE: begin
				if (take && action == bfa_pkg::ACT_LOAD && in_table) begin
					ram_we = 1'b1;
				end
				if (take && action == bfa_pkg::ACT_READ && in_table) begin
					ram_re = 1'b1;
				end
			end
			ST_SCAN: begin
				ram_re    = issue;
				ram_raddr = IW'(rd_q);
			end
			ST_FIN: begin
				ram_we    = found_q;
				ram_waddr = best_idx_q;
				ram_wdata = best_left_q;
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	bfa_ram #(
		.WIDTH (SW),
		.DEPTH (bfa_pkg::NUM_BLOCKS)
	) u_table (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= bfa_pkg::MODE_FIRST;
			block_count_q <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bfa_pkg::CFG_FIT_MODE:    fit_mode_q    <= cfg_data[1:0];
				bfa_pkg::CFG_BLOCK_COUNT: block_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-entry valid flags: an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			vld_s1 <= valid_q[ram_raddr];
			idx_s1 <= ram_raddr;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chk_s1  <= 1'b0;
			done    <= 1'b0;
			found_q <= 1'b0;
			rd_q    <= '0;
		end else begin
			done   <= 1'b0;
			chk_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (action)
							bfa_pkg::ACT_LOAD: begin
								done <= 1'b1;
							end
							bfa_pkg::ACT_ALLOC: begin
								state_q <= ST_SCAN;
								rd_q    <= '0;
								found_q <= 1'b0;
							end
							bfa_pkg::ACT_READ: begin
								state_q <= ST_READ;
							end
							default: begin
								done <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (chk_s1 && fits && better) begin
						found_q <= 1'b1;
					end
					if (issue) begin
						chk_s1 <= 1'b1;
						rd_q   <= rd_q + CW'(1);
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_READ: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_FIN: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// search datapath and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				job_q   <= amt;
				limit_q <= limit_d;
				if (take) begin
					if (action == bfa_pkg::ACT_LOAD && in_table) begin
						granted     <= 1'b1;
						block_index <= block_sel;
						space_left  <= 16'(amt);
					end else begin
						granted     <= 1'b0;
						block_index <= '0;
						space_left  <= '0;
					end
				end
			end
			ST_SCAN: begin
				if (chk_s1 && fits && better) begin
					best_left_q <= left;
					best_idx_q  <= idx_s1;
				end
			end
			ST_READ: begin
				// a 6-bit select always lands inside the table
				granted     <= 1'b1;
				block_index <= 6'(idx_s1);
				space_left  <= 16'(space);
			end
			ST_FIN: begin
				granted     <= found_q;
				block_index <= found_q ? 6'(best_idx_q) : '0;
				space_left  <= found_q ? 16'(best_left_q) : '0;
			end
			default: ;
		endcase
	end

	`BFA_ASSERT_IMP(a_fail_zero, clk, arst_n, done && !granted, block_index == '0 && space_left == '0)
	`BFA_ASSERT_NXT(a_alloc_busy, clk, arst_n, take && action == bfa_pkg::ACT_ALLOC, busy && !done)
	`BFA_ASSERT_IMP(a_scan_bound, clk, arst_n, state_q == ST_SCAN, rd_q <= limit_q)
	`BFA_ASSERT_IMP(a_idle_no_chk, clk, arst_n, !busy, !chk_s1)
	`BFA_ASSERT_IMP(a_one_write, clk, arst_n, state_q == ST_FIN, !ram_re)
endmodule
`default_nettype wire

// ===== src/bfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire logic [WIDTH-1:0]           wr_data,
	input  wire logic                       rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic      [WIDTH-1:0]           rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire
